FILE: rtl/smf_pkg.sv
// Shared types and constants for the sliding median filter.
package smf_pkg;

  // Sequencer states for one sample's rank pass.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COUNT,
    ST_DONE
  } smf_state_e;

  // Control that every cell of the chain sees at once.
  typedef struct packed {
    logic load;   // copy own entry into the travel slot, clear the rank
    logic step;   // compare against the travel slot, then pass it on
  } smf_cell_ctrl_t;

  localparam int unsigned SizeWidth = 5;
  localparam logic [SizeWidth-1:0] SizeReset = 5'd16;

  // Register indexes, taken from byte address bit 2.
  localparam logic RegWindowSize = 1'b0;

endpackage

FILE: rtl/smf_cell.sv
// One window entry with its rank counter and a travel slot of the ring.
module smf_cell
  import smf_pkg::*;
#(
  parameter int unsigned SW    = 16,
  parameter int unsigned IW    = 4,
  parameter int unsigned INDEX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  smf_cell_ctrl_t       ctrl_i,
  input  logic                 wr_i,
  input  logic signed [SW-1:0] sample_i,
  input  logic                 in_win_i,
  input  logic signed [SW-1:0] trav_val_i,
  input  logic [IW-1:0]        trav_idx_i,
  input  logic                 trav_win_i,
  output logic signed [SW-1:0] trav_val_o,
  output logic [IW-1:0]        trav_idx_o,
  output logic                 trav_win_o,
  output logic signed [SW-1:0] value_o,
  output logic [IW-1:0]        rank_o
);

  localparam logic [IW-1:0] OwnIdx = IW'(INDEX);

  logic signed [SW-1:0] value_q;
  logic signed [SW-1:0] tval_q;
  logic [IW-1:0]        tidx_q;
  logic                 twin_q;
  logic [IW-1:0]        rank_q, rank_d;
  logic                 below;

  // Ties are broken by index, so every window entry gets a distinct rank.
  assign below = twin_q && ((tval_q < value_q) || ((tval_q == value_q) && (tidx_q < OwnIdx)));

  always_comb begin
    rank_d = rank_q;
    if (ctrl_i.load) begin
      rank_d = '0;
    end else if (ctrl_i.step && below) begin
      rank_d = rank_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (wr_i) begin
      value_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    if (ctrl_i.load) begin
      tval_q <= value_q;
      tidx_q <= OwnIdx;
      twin_q <= in_win_i;
    end else if (ctrl_i.step) begin
      tval_q <= trav_val_i;
      tidx_q <= trav_idx_i;
      twin_q <= trav_win_i;
    end
  end

  assign trav_val_o = tval_q;
  assign trav_idx_o = tidx_q;
  assign trav_win_o = twin_q;
  assign value_o    = value_q;
  assign rank_o     = rank_q;

endmodule

FILE: rtl/sliding_median_filter_top.sv
// Top level of the sliding median filter: sequencer, config register and cell ring.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid_i, in_ready_o, sample_i          | in
//   output  | out_valid_o, out_ready_i, median_o        | out
//   config  | psel, penable, pwrite, paddr, pwdata,     | in/out
//           | prdata, pready                            |
//
// For each sample the sequencer writes the entry, loads the travel slots, runs
// WINDOW_DEPTH ring shifts in which every cell ranks itself against each passing
// entry, and then moves the median into the output register.
// The next sample transfer is taken while a median still waits in the output register.
// Reset clears the window to zeros, the write position to zero and the size to 16.
// A stalled output holds the sequencer in its last state until the slot frees.
module sliding_median_filter_top
  import smf_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] median_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned N  = WINDOW_DEPTH;
  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned EW = $clog2(N + 1);
  localparam logic [IW-1:0] LastStep = IW'(N - 1);

  // Configuration register.
  logic [SizeWidth-1:0] size_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegWindowSize);
  assign prdata = (paddr[2] == RegWindowSize) ? {{(32 - SizeWidth){1'b0}}, size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_wr) begin
      size_q <= pwdata[SizeWidth-1:0];
    end
  end

  // Effective window size, clamped to 1..N.
  logic [31:0]   size32, eff32;
  logic [EW-1:0] eff;
  logic [IW-1:0] mid;

  assign size32 = {{(32 - SizeWidth){1'b0}}, size_q};
  always_comb begin
    if (size32 == 32'd0) begin
      eff32 = 32'd1;
    end else if (size32 > N) begin
      eff32 = N;
    end else begin
      eff32 = size32;
    end
  end
  assign eff = eff32[EW-1:0];
  assign mid = IW'(eff32 >> 1);

  // Sequencer.
  smf_state_e     state_q, state_d;
  smf_cell_ctrl_t ctrl;
  logic [IW-1:0]  cnt_q;
  logic           accept;
  logic           out_load;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_COUNT;
      ST_COUNT: if (cnt_q == LastStep) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_o || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.step  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_LOAD:  ctrl.load = 1'b1;
      ST_COUNT: ctrl.step = 1'b1;
      ST_DONE:  out_load = !out_valid_o || out_ready_i;
      default:  in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      cnt_q <= '0;
    end else if (ctrl.step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Write position: wraps to zero if the window shrank below it.
  logic [IW-1:0] wp_q, wp_d, wpos;
  logic [31:0]   wp32, next32;

  assign wp32   = 32'(wp_q);
  assign wpos   = (wp32 >= eff32) ? '0 : wp_q;
  assign next32 = 32'(wpos) + 32'd1;
  assign wp_d   = (next32 >= eff32) ? '0 : IW'(next32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else if (accept) begin
      wp_q <= wp_d;
    end
  end

  // Cell ring.
  logic signed [SW-1:0] cell_val  [N];
  logic [IW-1:0]        cell_rank [N];
  logic signed [SW-1:0] trav_val  [N];
  logic [IW-1:0]        trav_idx  [N];
  logic                 trav_win  [N];

  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int unsigned Prev = (k == 0) ? N - 1 : k - 1;
    localparam logic [EW-1:0] KIdx = EW'(k);
    smf_cell #(
      .SW    (SW),
      .IW    (IW),
      .INDEX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_i       (accept && (wpos == IW'(k))),
      .sample_i   (sample_i),
      .in_win_i   (KIdx < eff),
      .trav_val_i (trav_val[Prev]),
      .trav_idx_i (trav_idx[Prev]),
      .trav_win_i (trav_win[Prev]),
      .trav_val_o (trav_val[k]),
      .trav_idx_o (trav_idx[k]),
      .trav_win_o (trav_win[k]),
      .value_o    (cell_val[k]),
      .rank_o     (cell_rank[k])
    );
  end

  // Exactly one window entry holds the middle rank.
  logic [SW-1:0] med_sel;
  always_comb begin
    med_sel = '0;
    for (int k = 0; k < N; k++) begin
      if ((EW'(k) < eff) && (cell_rank[k] == mid)) begin
        med_sel = med_sel | cell_val[k];
      end
    end
  end

  // Output register.
  logic          out_valid_q;
  logic [SW-1:0] median_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      median_q <= med_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

endmodule
